[sv/mse_pkg.sv]
// Shared types, codes and constants for the MIPS subset execute unit.
package mse_pkg;

	// Core dimensions
	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int PC_W      = 16;
	localparam int LEN_W     = 16;
	localparam int XLEN      = 32;

	// Decode queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Instruction match masks and patterns
	localparam logic [XLEN-1:0] MASK_RTYPE  = 32'hFC0007FF;
	localparam logic [XLEN-1:0] MASK_OPCODE = 32'hFC000000;
	localparam logic [XLEN-1:0] OP_ADD      = 32'h00000020;
	localparam logic [XLEN-1:0] OP_SUB      = 32'h00000022;
	localparam logic [XLEN-1:0] OP_SLT      = 32'h0000002A;
	localparam logic [XLEN-1:0] OP_MUL      = 32'h70000002;
	localparam logic [XLEN-1:0] OP_SYSCALL  = 32'h0000000C;
	localparam logic [XLEN-1:0] OP_BEQ      = 32'h10000000;
	localparam logic [XLEN-1:0] OP_BNE      = 32'h14000000;
	localparam logic [XLEN-1:0] OP_ADDI     = 32'h20000000;
	localparam logic [XLEN-1:0] OP_ORI      = 32'h34000000;
	localparam logic [XLEN-1:0] OP_LUI      = 32'h3C000000;

	// Syscall service registers and codes
	localparam logic [REG_IDX_W-1:0] REG_ZERO = 5'd0;
	localparam logic [REG_IDX_W-1:0] REG_V0   = 5'd2;
	localparam logic [REG_IDX_W-1:0] REG_A0   = 5'd4;
	localparam logic [XLEN-1:0] SYS_PRINT_INT  = 32'd1;
	localparam logic [XLEN-1:0] SYS_EXIT       = 32'd10;
	localparam logic [XLEN-1:0] SYS_PRINT_CHAR = 32'd11;

	typedef enum logic [2:0] {
		ST_RUN     = 3'd0,
		ST_EXIT    = 3'd1,
		ST_END     = 3'd2,
		ST_BRANCH  = 3'd3,
		ST_SYSCALL = 3'd4,
		ST_INVALID = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PK_NONE = 2'd0,
		PK_INT  = 2'd1,
		PK_CHAR = 2'd2
	} print_kind_t;

	typedef enum logic [3:0] {
		CL_ADD,
		CL_SUB,
		CL_SLT,
		CL_MUL,
		CL_SYSCALL,
		CL_BEQ,
		CL_BNE,
		CL_ADDI,
		CL_ORI,
		CL_LUI,
		CL_INVALID
	} op_class_t;

	// One decoded instruction
	typedef struct packed {
		op_class_t            cls;
		logic [REG_IDX_W-1:0] src_a;
		logic [REG_IDX_W-1:0] src_b;
		logic [REG_IDX_W-1:0] dest;
		logic [15:0]          imm;
	} q_entry_t;

	// Front to queue
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	// Queue head to back
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

endpackage

[sv/mse_front.sv]
// Front end: accepts instruction words and classifies them into queue entries.
module mse_front (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           instruction_word,
	input  logic                  q_full,
	output mse_pkg::q_push_t      push
);

	logic [mse_pkg::XLEN-1:0]      rtype;
	logic [mse_pkg::XLEN-1:0]      opc;
	logic [mse_pkg::REG_IDX_W-1:0] rs;
	logic [mse_pkg::REG_IDX_W-1:0] rt;
	logic [mse_pkg::REG_IDX_W-1:0] rd;
	mse_pkg::q_entry_t             ent;

	assign rtype = instruction_word & mse_pkg::MASK_RTYPE;
	assign opc   = instruction_word & mse_pkg::MASK_OPCODE;
	assign rs    = instruction_word[25:21];
	assign rt    = instruction_word[20:16];
	assign rd    = instruction_word[15:11];

	// Classify; syscall reads v0 and a0 through the two operand ports
	always_comb begin
		ent.cls   = mse_pkg::CL_INVALID;
		ent.src_a = rs;
		ent.src_b = rt;
		ent.dest  = mse_pkg::REG_ZERO;
		ent.imm   = instruction_word[15:0];
		if (rtype == mse_pkg::OP_ADD) begin
			ent.cls  = mse_pkg::CL_ADD;
			ent.dest = rd;
		end else if (rtype == mse_pkg::OP_SUB) begin
			ent.cls  = mse_pkg::CL_SUB;
			ent.dest = rd;
		end else if (rtype == mse_pkg::OP_SLT) begin
			ent.cls  = mse_pkg::CL_SLT;
			ent.dest = rd;
		end else if (rtype == mse_pkg::OP_MUL) begin
			ent.cls  = mse_pkg::CL_MUL;
			ent.dest = rd;
		end else if (rtype == mse_pkg::OP_SYSCALL) begin
			ent.cls   = mse_pkg::CL_SYSCALL;
			ent.src_a = mse_pkg::REG_V0;
			ent.src_b = mse_pkg::REG_A0;
		end else if (opc == mse_pkg::OP_BEQ) begin
			ent.cls = mse_pkg::CL_BEQ;
		end else if (opc == mse_pkg::OP_BNE) begin
			ent.cls = mse_pkg::CL_BNE;
		end else if (opc == mse_pkg::OP_ADDI) begin
			ent.cls  = mse_pkg::CL_ADDI;
			ent.dest = rt;
		end else if (opc == mse_pkg::OP_ORI) begin
			ent.cls  = mse_pkg::CL_ORI;
			ent.dest = rt;
		end else if (opc == mse_pkg::OP_LUI) begin
			ent.cls  = mse_pkg::CL_LUI;
			ent.dest = rt;
		end
	end

	// Transfer into the queue whenever it has room
	assign in_stall   = q_full;
	assign push.valid = in_valid & ~q_full;
	assign push.entry = ent;

endmodule

[sv/mse_queue.sv]
// Short FIFO of decoded instructions between front end and back end.
module mse_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mse_pkg::q_push_t      push,
	output logic                  full,
	output mse_pkg::q_head_t      head,
	input  logic                  pop
);

	mse_pkg::q_entry_t               entry_q [mse_pkg::QUEUE_DEPTH];
	logic [mse_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [mse_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [mse_pkg::QUEUE_CNT_W-1:0] count_q;

	localparam logic [mse_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
		mse_pkg::QUEUE_PTR_W'(mse_pkg::QUEUE_DEPTH - 1);
	localparam logic [mse_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
		mse_pkg::QUEUE_CNT_W'(mse_pkg::QUEUE_DEPTH);

	assign full       = (count_q == DEPTH_CNT);
	assign head.valid = (count_q != '0);
	assign head.entry = entry_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (count_q != DEPTH_CNT))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");

endmodule

[sv/mse_back.sv]
// Back end: register file, execute stage, program counter and result register.
module mse_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,
	input  mse_pkg::q_head_t      head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           next_pc,
	output logic [2:0]            status,
	output logic [1:0]            print_kind,
	output logic signed [31:0]    print_value,
	output logic [4:0]            write_index,
	output logic signed [31:0]    write_value
);

	localparam int RI = mse_pkg::REG_IDX_W;
	localparam int XL = mse_pkg::XLEN;
	localparam int PW = mse_pkg::PC_W;

	// Register file storage and written flags
	logic [XL-1:0]                  rf_mem [mse_pkg::REG_COUNT];
	logic [mse_pkg::REG_COUNT-1:0]  rf_vld_q;
	logic                           fwd_vld_q;
	logic [RI-1:0]                  fwd_idx_q;
	logic [XL-1:0]                  fwd_val_q;

	// Execute stage
	logic                           valid_s2;
	mse_pkg::op_class_t             cls_s2;
	logic [RI-1:0]                  src_a_s2;
	logic [RI-1:0]                  src_b_s2;
	logic [RI-1:0]                  dest_s2;
	logic [15:0]                    imm_s2;
	logic [XL-1:0]                  rdat_a_s2;
	logic [XL-1:0]                  rdat_b_s2;
	logic                           rvld_a_s2;
	logic                           rvld_b_s2;

	// Architectural state
	logic [PW-1:0]                  pc_q;
	logic [mse_pkg::LEN_W-1:0]      len_q;

	// Result register
	logic                           out_valid_q;
	logic [PW-1:0]                  out_pc_q;
	mse_pkg::status_t               out_status_q;
	mse_pkg::print_kind_t           out_kind_q;
	logic [XL-1:0]                  out_print_q;
	logic [RI-1:0]                  out_widx_q;
	logic [XL-1:0]                  out_wval_q;

	// Execute results
	logic                           fire;
	logic                           load_s2;
	logic [XL-1:0]                  opnd_a;
	logic [XL-1:0]                  opnd_b;
	logic [XL-1:0]                  mul_lo;
	logic [17:0]                    pc_ext;
	logic [17:0]                    imm_sx;
	logic [17:0]                    target;
	logic                           at_end;
	logic                           advance;
	logic                           has_dest;
	logic [XL-1:0]                  res_val;
	mse_pkg::status_t               res_status;
	mse_pkg::print_kind_t           res_kind;
	logic [XL-1:0]                  res_print;
	logic [PW-1:0]                  res_pc;
	logic                           wr_en;

	// Stage handshakes
	assign fire    = valid_s2 & (~out_valid_q | ~out_stall);
	assign load_s2 = head.valid & (~valid_s2 | fire);
	assign pop     = load_s2;

	// Operand select: latest write bypasses the same-edge register read
	always_comb begin
		if (fwd_vld_q && fwd_idx_q == src_a_s2) begin
			opnd_a = fwd_val_q;
		end else begin
			opnd_a = rvld_a_s2 ? rdat_a_s2 : '0;
		end
		if (fwd_vld_q && fwd_idx_q == src_b_s2) begin
			opnd_b = fwd_val_q;
		end else begin
			opnd_b = rvld_b_s2 ? rdat_b_s2 : '0;
		end
	end

	assign mul_lo = opnd_a * opnd_b;
	assign pc_ext = {2'b00, pc_q};
	assign imm_sx = {{2{imm_s2[15]}}, imm_s2};
	assign at_end = (pc_q >= len_q);

	// Execute one instruction
	always_comb begin
		res_status = mse_pkg::ST_RUN;
		res_kind   = mse_pkg::PK_NONE;
		res_print  = '0;
		res_val    = '0;
		has_dest   = 1'b0;
		advance    = 1'b1;
		target     = pc_ext + 18'd1;
		if (at_end) begin
			res_status = mse_pkg::ST_END;
			advance    = 1'b0;
		end else begin
			unique case (cls_s2)
				mse_pkg::CL_ADD: begin
					res_val  = opnd_a + opnd_b;
					has_dest = 1'b1;
				end
				mse_pkg::CL_SUB: begin
					res_val  = opnd_a - opnd_b;
					has_dest = 1'b1;
				end
				mse_pkg::CL_SLT: begin
					res_val  = {{(XL-1){1'b0}}, ($signed(opnd_a) < $signed(opnd_b))};
					has_dest = 1'b1;
				end
				mse_pkg::CL_MUL: begin
					res_val  = mul_lo;
					has_dest = 1'b1;
				end
				mse_pkg::CL_SYSCALL: begin
					if (opnd_a == mse_pkg::SYS_PRINT_INT) begin
						res_kind  = mse_pkg::PK_INT;
						res_print = opnd_b;
					end else if (opnd_a == mse_pkg::SYS_PRINT_CHAR) begin
						res_kind  = mse_pkg::PK_CHAR;
						res_print = opnd_b;
					end else if (opnd_a == mse_pkg::SYS_EXIT) begin
						res_status = mse_pkg::ST_EXIT;
						advance    = 1'b0;
					end else begin
						res_status = mse_pkg::ST_SYSCALL;
						advance    = 1'b0;
					end
				end
				mse_pkg::CL_BEQ, mse_pkg::CL_BNE: begin
					if ((cls_s2 == mse_pkg::CL_BEQ) == (opnd_a == opnd_b)) begin
						target = pc_ext + imm_sx;
						if (target[17]) begin
							res_status = mse_pkg::ST_BRANCH;
							advance    = 1'b0;
						end
					end
				end
				mse_pkg::CL_ADDI: begin
					res_val  = opnd_a + {{(XL-16){imm_s2[15]}}, imm_s2};
					has_dest = 1'b1;
				end
				mse_pkg::CL_ORI: begin
					res_val  = opnd_a | {{(XL-16){1'b0}}, imm_s2};
					has_dest = 1'b1;
				end
				mse_pkg::CL_LUI: begin
					res_val  = {imm_s2, 16'h0000};
					has_dest = 1'b1;
				end
				default: begin
					res_status = mse_pkg::ST_INVALID;
					advance    = 1'b0;
				end
			endcase
		end

		// Clamp the new program counter at the program end
		if (at_end) begin
			res_pc = len_q;
		end else if (advance) begin
			if (target[16:0] >= {1'b0, len_q}) begin
				res_pc     = len_q;
				res_status = mse_pkg::ST_END;
			end else begin
				res_pc = target[PW-1:0];
			end
		end else begin
			res_pc = pc_q;
		end
	end

	assign wr_en = has_dest & (dest_s2 != mse_pkg::REG_ZERO);

	// Register file write and registered operand read
	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			rf_mem[dest_s2] <= res_val;
		end
		if (load_s2) begin
			rdat_a_s2 <= rf_mem[head.entry.src_a];
			rdat_b_s2 <= rf_mem[head.entry.src_b];
		end
	end

	// Written flags and bypass register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			fwd_vld_q <= 1'b0;
		end else if (fire && wr_en) begin
			rf_vld_q[dest_s2] <= 1'b1;
			fwd_vld_q         <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			fwd_idx_q <= dest_s2;
			fwd_val_q <= res_val;
		end
	end

	// Execute stage payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			cls_s2    <= head.entry.cls;
			src_a_s2  <= head.entry.src_a;
			src_b_s2  <= head.entry.src_b;
			dest_s2   <= head.entry.dest;
			imm_s2    <= head.entry.imm;
			rvld_a_s2 <= rf_vld_q[head.entry.src_a];
			rvld_b_s2 <= rf_vld_q[head.entry.src_b];
		end
	end

	// Control state: stage valid, result valid, program counter, program length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
			len_q       <= '0;
		end else begin
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				pc_q        <= res_pc;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				len_q <= cfg_wr_data;
			end
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk) begin
		if (fire) begin
			out_pc_q     <= res_pc;
			out_status_q <= res_status;
			out_kind_q   <= res_kind;
			out_print_q  <= res_print;
			out_widx_q   <= wr_en ? dest_s2 : mse_pkg::REG_ZERO;
			out_wval_q   <= wr_en ? res_val : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign next_pc     = out_pc_q;
	assign status      = out_status_q;
	assign print_kind  = out_kind_q;
	assign print_value = out_print_q;
	assign write_index = out_widx_q;
	assign write_value = out_wval_q;

	a_r0_never_written: assert property (@(posedge clk) disable iff (!arst_n)
		!rf_vld_q[0] && !(fwd_vld_q && fwd_idx_q == mse_pkg::REG_ZERO))
		else $error("register zero marked as written");

	a_end_clamps_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_status == mse_pkg::ST_END) |-> (res_pc == len_q))
		else $error("end status without clamped pc");

	a_halt_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (res_status == mse_pkg::ST_EXIT || res_status == mse_pkg::ST_BRANCH ||
			res_status == mse_pkg::ST_SYSCALL || res_status == mse_pkg::ST_INVALID))
		|=> (pc_q == $past(pc_q)))
		else $error("pc moved on a halting status");

endmodule

[sv/mips_subset_execute_unit.sv]
// Top level of the MIPS subset execute unit: front end, decode queue, back end.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    instruction_word
//   out       output     out_valid / out_stall  next_pc, status, print_kind,
//                                               print_value, write_index, write_value
//   cfg       input      cfg_wr_en              cfg_wr_data (program_length)
//
// One instruction per cycle sustained while out_stall is low; the result is registered.
// The execute stage with its single register-file write port sets that rate; operands read
// in the same cycle as the previous write are taken from a bypass register.
// Reset clears register-file written flags, program counter, program length and all valids.
// out_stall holds the result register; the execute stage and a two-entry queue absorb the
// backlog, and in_stall rises only when the queue is full.
module mips_subset_execute_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           instruction_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           next_pc,
	output logic [2:0]            status,
	output logic [1:0]            print_kind,
	output logic signed [31:0]    print_value,
	output logic [4:0]            write_index,
	output logic signed [31:0]    write_value
);

	mse_pkg::q_push_t push;
	mse_pkg::q_head_t head;
	logic             q_full;
	logic             pop;

	mse_front u_front (
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.instruction_word (instruction_word),
		.q_full           (q_full),
		.push             (push)
	);

	mse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	mse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.next_pc     (next_pc),
		.status      (status),
		.print_kind  (print_kind),
		.print_value (print_value),
		.write_index (write_index),
		.write_value (write_value)
	);

endmodule

[verif/mse_exec_monitor.sv]
// Monitor for the MIPS subset execute unit: predicts every retired instruction and compares.
module mse_exec_monitor
	import mse_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [31:0]        instruction_word,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [15:0]        next_pc,
	input  logic [2:0]         status,
	input  logic [1:0]         print_kind,
	input  logic signed [31:0] print_value,
	input  logic [4:0]         write_index,
	input  logic signed [31:0] write_value,
	output int                 fail_count,
	output int                 outstanding
);

	typedef struct packed {
		logic [PC_W-1:0]      next_pc;
		status_t              status;
		print_kind_t          kind;
		logic [XLEN-1:0]      pval;
		logic [REG_IDX_W-1:0] widx;
		logic [XLEN-1:0]      wval;
	} retire_t;

	// Architectural state as the core should see it
	logic [XLEN-1:0]  arch_regs [REG_COUNT];
	logic [PC_W-1:0]  arch_pc;
	logic [LEN_W-1:0] prog_len;

	retire_t expected_retires[$];
	retire_t want;
	logic    bad;

	function automatic logic [XLEN-1:0] read_reg(input logic [REG_IDX_W-1:0] idx);
		return (idx == REG_ZERO) ? '0 : arch_regs[idx];
	endfunction

	// Execute one instruction against the architectural state and return what retires
	function automatic retire_t execute_instruction(input logic [XLEN-1:0] ins);
		logic [REG_IDX_W-1:0] rs, rt, rd;
		logic [15:0]          imm;
		logic [XLEN-1:0]      a, b, svc, res, rtype, opcode;
		logic                 has_dest, advance, taken;
		int                   target;
		retire_t              r;
		rs = ins[25:21];
		rt = ins[20:16];
		rd = ins[15:11];
		imm = ins[15:0];
		a = read_reg(rs);
		b = read_reg(rt);
		rtype = ins & MASK_RTYPE;
		opcode = ins & MASK_OPCODE;
		res = '0;
		has_dest = 1'b0;
		advance = 1'b1;
		target = int'(arch_pc) + 1;
		r.next_pc = '0;
		r.status = ST_RUN;
		r.kind = PK_NONE;
		r.pval = '0;
		r.widx = '0;
		r.wval = '0;

		// Entry at or past the end: park on the end without executing
		if (arch_pc >= prog_len) begin
			arch_pc = prog_len;
			r.next_pc = prog_len;
			r.status = ST_END;
			return r;
		end

		if (rtype == OP_ADD) begin
			has_dest = 1'b1; r.widx = rd; res = a + b;
		end else if (rtype == OP_SUB) begin
			has_dest = 1'b1; r.widx = rd; res = a - b;
		end else if (rtype == OP_SLT) begin
			has_dest = 1'b1; r.widx = rd; res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
		end else if (rtype == OP_MUL) begin
			has_dest = 1'b1; r.widx = rd; res = a * b;
		end else if (rtype == OP_SYSCALL) begin
			svc = read_reg(REG_V0);
			if (svc == SYS_PRINT_INT) begin
				r.kind = PK_INT; r.pval = read_reg(REG_A0);
			end else if (svc == SYS_PRINT_CHAR) begin
				r.kind = PK_CHAR; r.pval = read_reg(REG_A0);
			end else if (svc == SYS_EXIT) begin
				r.status = ST_EXIT; advance = 1'b0;
			end else begin
				r.status = ST_SYSCALL; advance = 1'b0;
			end
		end else if (opcode == OP_BEQ || opcode == OP_BNE) begin
			taken = (opcode == OP_BEQ) ? (a == b) : (a != b);
			if (taken) begin
				target = int'(arch_pc) + int'($signed(imm));
				// a target below zero holds the core on the branch
				if (target < 0) begin
					r.status = ST_BRANCH; advance = 1'b0;
				end
			end
		end else if (opcode == OP_ADDI) begin
			has_dest = 1'b1; r.widx = rt; res = a + {{16{imm[15]}}, imm};
		end else if (opcode == OP_ORI) begin
			has_dest = 1'b1; r.widx = rt; res = a | {16'h0000, imm};
		end else if (opcode == OP_LUI) begin
			has_dest = 1'b1; r.widx = rt; res = {imm, 16'h0000};
		end else begin
			r.status = ST_INVALID; advance = 1'b0;
		end

		// Drop writes to register zero
		if (has_dest && r.widx != REG_ZERO) begin
			arch_regs[r.widx] = res;
			r.wval = res;
		end

		// Advance the program counter, clamping at the end
		if (advance) begin
			if (target >= int'(prog_len)) begin
				target = int'(prog_len);
				r.status = ST_END;
			end
			arch_pc = target[PC_W-1:0];
		end
		r.next_pc = arch_pc;
		return r;
	endfunction

	// Check result transfers, track configuration, predict input transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (arch_regs[i])
				arch_regs[i] = '0;
			arch_pc = '0;
			prog_len = '0;
			expected_retires.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_retires.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: next_pc %0d status %0d write r%0d=%h",
							next_pc, status, write_index, write_value);
				end else begin
					want = expected_retires.pop_front();
					bad = (next_pc !== want.next_pc) || (status !== want.status) ||
						(print_kind !== want.kind) || (print_value !== want.pval) ||
						(write_index !== want.widx) || (write_value !== want.wval);
					if (bad) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result mismatch: expected pc %0d st %0d pk %0d pv %h w r%0d=%h",
								want.next_pc, want.status, want.kind, want.pval, want.widx,
								want.wval);
							$display("                 got      pc %0d st %0d pk %0d pv %h w r%0d=%h",
								next_pc, status, print_kind, print_value,
								write_index, write_value);
						end
					end
				end
			end
			if (cfg_wr_en)
				prog_len = cfg_wr_data;
			if (in_valid && !in_stall)
				expected_retires.push_back(execute_instruction(instruction_word));
			outstanding = expected_retires.size();
		end
	end

endmodule

[verif/tb_mips_subset_execute_unit.sv]
// Testbench top for the MIPS subset execute unit: instruction stimulus, back-pressure and verdict.
module tb_mips_subset_execute_unit;
	import mse_pkg::*;

	localparam int INSTR_TARGET = 1150;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [15:0]        cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [31:0]        instruction_word = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        next_pc;
	logic [2:0]         status;
	logic [1:0]         print_kind;
	logic signed [31:0] print_value;
	logic [4:0]         write_index;
	logic signed [31:0] write_value;
	int                 fail_count;
	int                 outstanding;
	logic               gaps_on = 1'b1;
	int                 instr_sent = 0;

	mips_subset_execute_unit i_dut (.*);

	mse_exec_monitor i_mon (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at random while gaps are enabled
	always @(negedge clk)
		out_stall <= gaps_on && ($urandom_range(99) < 35);

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [31:0] r_ins(input logic [31:0] pattern,
		input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] rd);
		return pattern | {6'b0, rs, rt, rd, 11'b0};
	endfunction

	function automatic logic [31:0] i_ins(input logic [31:0] opcode,
		input logic [4:0] rs, input logic [4:0] rt, input logic [15:0] imm);
		return opcode | {6'b0, rs, rt, imm};
	endfunction

	// Favor the low registers so values get reused, syscall registers among them
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(3) == 0) ? 5'($urandom()) : 5'($urandom_range(7));
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom());
		endcase
	endfunction

	// Present one instruction, hold it until the transfer; call and return at a falling edge
	task automatic send_instr(input logic [31:0] ins);
		while (gaps_on && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		instruction_word <= ins;
		do
			@(posedge clk);
		while (in_stall);
		instr_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_length(input logic [15:0] len);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Send one short program fragment: ALU, immediate, branch, syscall setup or noise
	task automatic send_random_group();
		int          pick;
		logic [31:0] opc;
		logic [15:0] val;
		pick = $urandom_range(99);
		if (pick < 30) begin
			case ($urandom_range(3))
				0: opc = OP_ADD;
				1: opc = OP_SUB;
				2: opc = OP_SLT;
				default: opc = OP_MUL;
			endcase
			send_instr(r_ins(opc, pick_reg(), pick_reg(), pick_reg()));
		end else if (pick < 50) begin
			case ($urandom_range(2))
				0: opc = OP_ADDI;
				1: opc = OP_ORI;
				default: opc = OP_LUI;
			endcase
			send_instr(i_ins(opc, pick_reg(), pick_reg(), pick_imm()));
		end else if (pick < 65) begin
			opc = $urandom_range(1) ? OP_BEQ : OP_BNE;
			val = ($urandom_range(9) == 0) ? pick_imm() : 16'(int'($urandom_range(12)) - 6);
			send_instr(i_ins(opc, pick_reg(), pick_reg(), val));
		end else if (pick < 85) begin
			case ($urandom_range(4))
				0: val = SYS_PRINT_INT[15:0];
				1: val = SYS_PRINT_CHAR[15:0];
				2: val = SYS_EXIT[15:0];
				default: val = 16'($urandom_range(15));
			endcase
			if ($urandom_range(1)) begin
				send_instr(i_ins(OP_LUI, REG_ZERO, REG_A0, pick_imm()));
				send_instr(i_ins(OP_ORI, REG_A0, REG_A0, pick_imm()));
			end
			send_instr(i_ins(OP_ADDI, REG_ZERO, REG_V0, val));
			send_instr(OP_SYSCALL);
		end else if (pick < 93) begin
			send_instr($urandom());
		end else begin
			send_instr({6'b0, 26'($urandom())});
		end
	endtask

	initial begin
		logic [31:0] directed_prog[$];
		int          phase;
		int          group_count;
		logic [15:0] len;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed program: field extremes, every operation, every status
		write_length(16'd30);
		directed_prog.push_back(i_ins(OP_LUI, REG_ZERO, 5'd1, 16'h8000));
		directed_prog.push_back(i_ins(OP_ORI, REG_ZERO, 5'd2, 16'hFFFF));
		directed_prog.push_back(i_ins(OP_ADDI, REG_ZERO, 5'd3, 16'hFFFF));
		directed_prog.push_back(i_ins(OP_ADDI, 5'd1, REG_A0, 16'hFFFF));
		directed_prog.push_back(r_ins(OP_ADD, REG_A0, REG_A0, 5'd5));
		directed_prog.push_back(r_ins(OP_SUB, 5'd1, 5'd3, 5'd6));
		directed_prog.push_back(r_ins(OP_SLT, 5'd1, REG_A0, 5'd7));
		directed_prog.push_back(r_ins(OP_SLT, REG_A0, 5'd1, 5'd8));
		directed_prog.push_back(r_ins(OP_MUL, REG_A0, REG_A0, 5'd31));
		directed_prog.push_back(r_ins(OP_ADD, REG_A0, REG_A0, REG_ZERO));
		directed_prog.push_back(i_ins(OP_ADDI, REG_ZERO, REG_V0, SYS_PRINT_INT[15:0]));
		directed_prog.push_back(OP_SYSCALL);
		directed_prog.push_back(i_ins(OP_ADDI, REG_ZERO, REG_V0, SYS_PRINT_CHAR[15:0]));
		directed_prog.push_back(OP_SYSCALL);
		directed_prog.push_back(i_ins(OP_ADDI, REG_ZERO, REG_V0, 16'd7));
		directed_prog.push_back(OP_SYSCALL);
		directed_prog.push_back(32'hFFFFFFFF);
		directed_prog.push_back(32'h00000000);
		directed_prog.push_back(i_ins(OP_BEQ, REG_ZERO, REG_ZERO, 16'hFF9C));
		directed_prog.push_back(i_ins(OP_BNE, 5'd1, REG_ZERO, 16'd2));
		directed_prog.push_back(i_ins(OP_BEQ, 5'd1, REG_ZERO, 16'd5));
		directed_prog.push_back(i_ins(OP_ADDI, REG_ZERO, REG_V0, SYS_EXIT[15:0]));
		directed_prog.push_back(OP_SYSCALL);
		directed_prog.push_back(OP_SYSCALL);
		directed_prog.push_back(i_ins(OP_BEQ, REG_ZERO, REG_ZERO, 16'd1000));
		directed_prog.push_back(r_ins(OP_ADD, 5'd1, 5'd1, 5'd9));
		foreach (directed_prog[i])
			send_instr(directed_prog[i]);

		// Random phases: rewind the program counter through a zero length, then run
		phase = 0;
		while (instr_sent < INSTR_TARGET) begin
			drain();
			gaps_on = (phase % 5 != 3);
			write_length(16'd0);
			send_instr(pick_imm() == 16'h0000 ? 32'h00000000 : $urandom());
			drain();
			case ($urandom_range(9))
				0: len = 16'd1;
				1: len = 16'hFFFF;
				2: len = 16'($urandom_range(2, 1000));
				default: len = 16'($urandom_range(16, 120));
			endcase
			write_length(len);
			group_count = $urandom_range(30, 110);
			repeat (group_count)
				send_random_group();
			phase++;
		end

		// Let the pipeline empty, then keep watching for stray results before the verdict
		drain();
		gaps_on = 1'b0;
		repeat (10) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
sv/mse_pkg.sv
sv/mse_front.sv
sv/mse_queue.sv
sv/mse_back.sv
sv/mips_subset_execute_unit.sv
verif/mse_exec_monitor.sv
verif/tb_mips_subset_execute_unit.sv
